/* src/lis_pkg.sv */
// Shared types and constants for the longest increasing subsequence length block.
package lis_pkg;

    // Width of one stored tail value.
    localparam int KEY_W = 32;

    // Width of the reported length field.
    localparam int RUN_LENGTH_W = 11;

    // Flipping the sign bit makes an unsigned compare order signed values correctly.
    localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;

    // One result item as produced by the sequencer.
    typedef struct packed {
        logic                    overflow;
        logic [RUN_LENGTH_W-1:0] run_length;
    } lis_result_t;

endpackage

/* src/lis_tail_ram.sv */
// Single write port, single registered read port memory for the tail values.
module lis_tail_ram
    import lis_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [KEY_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [KEY_W-1:0]  rd_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/lis_ctrl.sv */
// Sequencer that appends to or binary-searches the tail memory for each item.
module lis_ctrl
    import lis_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] in_value,
    input  logic               in_first,
    input  logic               out_free,
    output logic               res_valid,
    output lis_result_t        res
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAST_CMP,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic [IDX_W-1:0]   mid_reg, mid_next;
    logic               drop_reg, drop_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [KEY_W-1:0]   wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [KEY_W-1:0]   rd_data;

    logic [KEY_W-1:0]   in_key;
    logic               rd_less;
    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W-1:0]   lo_s;
    logic [IDX_W-1:0]   hi_s;
    logic [IDX_W:0]     mid_sum;

    lis_tail_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Compare unit for the search and search-window arithmetic.
    assign in_key   = $unsigned(in_value) ^ SIGN_FLIP;
    assign rd_less  = (rd_data < key_reg);
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign lo_s     = rd_less ? (mid_reg + IDX_W'(1)) : lo_reg;
    assign hi_s     = rd_less ? hi_reg : mid_reg;
    assign mid_sum  = {1'b0, lo_s} + {1'b0, hi_s};

    // Next-state, memory access and bookkeeping.
    always_comb begin
        state_next = state_reg;
        key_next   = key_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        drop_next  = drop_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = key_reg;
        rd_en      = 1'b0;
        rd_addr    = mid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    key_next  = in_key;
                    drop_next = 1'b0;
                    if (in_first || count_reg == '0) begin
                        // A new sequence, or an empty table, holds just this item.
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = in_key;
                        count_next = CNT_W'(1);
                        state_next = ST_DONE;
                    end else begin
                        // Fetch the last tail for the append check.
                        rd_en      = 1'b1;
                        rd_addr    = last_idx;
                        state_next = ST_LAST_CMP;
                    end
                end
            end
            ST_LAST_CMP: begin
                if (rd_data < key_reg) begin
                    // Larger than every tail: append unless the table is full.
                    if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                        drop_next = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = IDX_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_DONE;
                end else if (last_idx == '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    state_next = ST_DONE;
                end else begin
                    // The answer lies in [0, count-1]; probe the middle.
                    lo_next    = '0;
                    hi_next    = last_idx;
                    mid_next   = last_idx >> 1;
                    rd_en      = 1'b1;
                    rd_addr    = last_idx >> 1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                lo_next = lo_s;
                hi_next = hi_s;
                if (lo_s < hi_s) begin
                    mid_next = mid_sum[IDX_W:1];
                    rd_en    = 1'b1;
                    rd_addr  = mid_sum[IDX_W:1];
                end else begin
                    // First tail not below the item: overwrite it.
                    wr_en      = 1'b1;
                    wr_addr    = lo_s;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
        key_reg <= key_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign res_valid      = (state_reg == ST_DONE);
    assign res.run_length = RUN_LENGTH_W'(count_reg);
    assign res.overflow   = drop_reg;

endmodule

/* src/longest_increasing_subsequence_length.sv */
// Top level of the longest strictly increasing subsequence length block.
//
// Input channel (s_): one signed 32-bit value per item in s_tdata, and
// s_tuser high marks the first value of a new sequence. Output channel (m_):
// one item per input item, the current length in m_tdata and the table
// overflow flag in m_tuser.
// An item that starts a sequence or meets an empty table is written at once;
// otherwise the last tail is read and compared. A larger item is appended,
// or dropped if the table is full; else the first tail not below it is
// overwritten, found by a binary search over the tails in use that makes one
// read of the tail memory and one compare per cycle. The result waits in the
// sequencer's done state and is then taken into the output register.
// s_tready is high only while the sequencer is idle. A stalled receiver
// holds the output register; the next item may still be accepted, but its
// result waits in the sequencer until the register frees.
// Reset clears the length to zero and empties both channels; the tail
// memory is not cleared, since only written entries are ever read.
module longest_increasing_subsequence_length
    import lis_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [10:0] run_length, [15:11] zero
    output logic        m_tuser    // [0] overflow
);

    logic        res_valid;
    lis_result_t res;
    logic        out_free;
    logic        m_valid_reg;
    lis_result_t m_result_reg;

    assign out_free = !m_valid_reg || m_tready;

    lis_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  ($signed(s_tdata)),
        .in_first  (s_tuser),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register between the sequencer and the receiver.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
        if (out_free && res_valid) begin
            m_result_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(16 - RUN_LENGTH_W)'(0), m_result_reg.run_length};
    assign m_tuser  = m_result_reg.overflow;

    // An accepted item keeps the sequencer busy in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // A dropped append only happens with the table full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[10:0] == RUN_LENGTH_W'(TABLE_DEPTH))
        else $error("overflow reported with table not full");

    // A sequence start always reports a length of one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> res.run_length == RUN_LENGTH_W'(1)
            && !res.overflow)
        else $error("sequence start did not reset the length");

endmodule
